### design/addable_edge_source_finder_top_defines.svh
// Assertion macros shared by the addable edge source finder RTL.
`ifndef ADDABLE_EDGE_SOURCE_FINDER_TOP_DEFINES_SVH
`define ADDABLE_EDGE_SOURCE_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define AESF_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define AESF_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/aesf_pkg.sv
// Types and constants of the addable edge source finder.
package aesf_pkg;

  // Operation codes of the input word.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_PAIR  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_TWO_HOP    = 1'b1;

  // Reset value of the node count configuration register.
  localparam logic [6:0] NODE_COUNT_RST = 7'd64;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDROW,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

### design/aesf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module aesf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered and valid in the cycle after the enable.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/addable_edge_source_finder_top.sv
// Top level of the addable edge source finder: graph store and query sequencer.
//
//   Channel | Direction | Handshake           | Word
//   in_     | input     | in_tvalid/in_tready | operation, source, target
//   out_    | output    | out_tvalid/out_tready | mask, any, pair, range error
//   cfg_    | input     | cfg_valid/cfg_ready | register index, write data
//
// An in-range two-hop query or pair check first reads the target's row, then
// reads every in-range row from the row memory, one per cycle, through its
// single read port, then drains the last read. Other words go from the row
// read straight to the final state.
// Reset clears the row valid bits, so the graph starts empty without a sweep.
// A new word is taken while a finished result still waits at the output
// register; the sequencer holds in its final state only while that register
// is full and not taken.
`include "addable_edge_source_finder_top_defines.svh"

module addable_edge_source_finder_top
  import aesf_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input word: [1:0] operation, [7:2] source_node, [13:8] target_node.
  input  logic [15:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Result word: [63:0] addable_mask, [64] any_addable, [65] pair_addable,
  // [66] range_error.
  output logic [71:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int RW = MAX_NODES;
  localparam int IW = $clog2(MAX_NODES);
  localparam logic [6:0] MAXN7 = 7'(MAX_NODES);

  // Control registers.
  state_t         state_r, state_nxt;
  logic [RW-1:0]  vbits_r, vbits_nxt;
  logic           acc_sel_r, acc_sel_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [6:0]     nc_r;
  logic           hop_r;

  // Payload registers.
  logic [1:0]     op_r, op_nxt;
  logic [5:0]     s_r, s_nxt;
  logic [5:0]     t_r, t_nxt;
  logic           err_r, err_nxt;
  logic [RW-1:0]  vm_r, vm_nxt;
  logic [IW-1:0]  last_r, last_nxt;
  logic [RW-1:0]  direct_r, direct_nxt;
  logic [RW-1:0]  cand_r, cand_nxt;
  logic [IW-1:0]  m_r, m_nxt;
  logic           rowv_r, rowv_nxt;
  logic [63:0]    out_mask_r, out_mask_nxt;
  logic           out_any_r, out_any_nxt;
  logic           out_pair_r, out_pair_nxt;
  logic           out_err_r, out_err_nxt;

  // Memory port signals.
  logic           ram_we;
  logic [IW-1:0]  ram_waddr;
  logic [RW-1:0]  ram_wdata;
  logic           ram_re;
  logic [IW-1:0]  ram_raddr;
  logic [RW-1:0]  ram_rdata;

  // Helpers.
  logic [1:0]     in_op;
  logic [5:0]     in_s;
  logic [5:0]     in_t;
  logic [6:0]     eff7;
  logic           err_s, err_t;
  logic [RW-1:0]  row;
  logic [RW-1:0]  sbit, tbit;
  logic [RW-1:0]  mask_fin;
  logic [63:0]    mask64;
  logic           out_load;

  assign in_op = in_tdata[1:0];
  assign in_s  = in_tdata[7:2];
  assign in_t  = in_tdata[13:8];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_err_r, out_pair_r, out_any_r, out_mask_r};

  // Node count saturates at the store's depth.
  assign eff7  = (nc_r > MAXN7) ? MAXN7 : nc_r;
  assign err_s = ({1'b0, in_s} >= eff7);
  assign err_t = ({1'b0, in_t} >= eff7);

  // Target row as read, empty when the row was never written.
  assign row = rowv_r ? ram_rdata : '0;

  // One-hot masks of the latched source and target.
  always_comb begin
    for (int i = 0; i < RW; i++) begin
      sbit[i] = (s_r == 6'(i));
      tbit[i] = (t_r == 6'(i));
    end
  end

  // Final candidate set: in range, not a direct in-neighbor, not the target.
  assign mask_fin = cand_r & vm_r & ~direct_r & ~tbit;
  assign mask64   = 64'(mask_fin);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // Row memory: bit s of row t set when edge s->t exists.
  aesf_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_NODES)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers, written by the user only while idle (unenforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r  <= NODE_COUNT_RST;
      hop_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NODE_COUNT: nc_r  <= cfg_data;
        CFG_TWO_HOP:    hop_r <= cfg_data[0];
      endcase
    end
  end

  // Sequencer next state and memory accesses.
  always_comb begin
    state_nxt     = state_r;
    vbits_nxt     = vbits_r;
    acc_sel_nxt   = 1'b0;
    op_nxt        = op_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    err_nxt       = err_r;
    vm_nxt        = vm_r;
    last_nxt      = last_r;
    direct_nxt    = direct_r;
    cand_nxt      = cand_r;
    m_nxt         = m_r;
    rowv_nxt      = rowv_r;
    ram_we        = 1'b0;
    ram_waddr     = t_r[IW-1:0];
    ram_wdata     = row | sbit;
    ram_re        = 1'b0;
    ram_raddr     = m_r;

    // Fold in the row read during the previous scan cycle.
    if (acc_sel_r) begin
      cand_nxt = cand_r | ram_rdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_op;
          s_nxt    = in_s;
          t_nxt    = in_t;
          case (in_op)
            OP_ADD, OP_PAIR: err_nxt = err_s | err_t;
            OP_QUERY:        err_nxt = err_t;
            default:         err_nxt = 1'b0;
          endcase
          for (int i = 0; i < RW; i++) begin
            vm_nxt[i] = (7'(i) < eff7);
          end
          last_nxt  = IW'(eff7 - 7'd1);
          ram_re    = 1'b1;
          ram_raddr = in_t[IW-1:0];
          rowv_nxt  = !err_t && vbits_r[in_t[IW-1:0]];
          state_nxt = ST_RDROW;
        end
      end
      ST_RDROW: begin
        direct_nxt = row & vm_r;
        if (op_r == OP_ADD && !err_r) begin
          // Set bit s in row t; repeated edges leave the row unchanged.
          ram_we                 = 1'b1;
          vbits_nxt[t_r[IW-1:0]] = 1'b1;
          cand_nxt               = '0;
          state_nxt              = ST_FIN;
        end else if ((op_r == OP_QUERY || op_r == OP_PAIR) && !err_r) begin
          if (hop_r) begin
            cand_nxt  = '0;
            m_nxt     = '0;
            state_nxt = ST_SCAN;
          end else begin
            cand_nxt  = '1;
            state_nxt = ST_FIN;
          end
        end else begin
          cand_nxt  = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        // Read row m; it joins the union when m is a direct in-neighbor.
        ram_re      = 1'b1;
        ram_raddr   = m_r;
        acc_sel_nxt = direct_r[m_r] & vbits_r[m_r];
        m_nxt       = m_r + 1'b1;
        if (m_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register next values.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_mask_nxt  = out_mask_r;
    out_any_nxt   = out_any_r;
    out_pair_nxt  = out_pair_r;
    out_err_nxt   = out_err_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_mask_nxt  = (op_r == OP_QUERY) ? mask64 : '0;
      out_any_nxt   = (op_r == OP_QUERY) && (mask64 != '0);
      out_pair_nxt  = (op_r == OP_PAIR) && mask64[s_r];
      out_err_nxt   = err_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vbits_r     <= '0;
      acc_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vbits_r     <= vbits_nxt;
      acc_sel_r   <= acc_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    s_r        <= s_nxt;
    t_r        <= t_nxt;
    err_r      <= err_nxt;
    vm_r       <= vm_nxt;
    last_r     <= last_nxt;
    direct_r   <= direct_nxt;
    cand_r     <= cand_nxt;
    m_r        <= m_nxt;
    rowv_r     <= rowv_nxt;
    out_mask_r <= out_mask_nxt;
    out_any_r  <= out_any_nxt;
    out_pair_r <= out_pair_nxt;
    out_err_r  <= out_err_nxt;
  end

  // Checks on the sequencer and the result register.
  `AESF_IMPLIES(a_we_only_add, ram_we, (state_r == ST_RDROW) && (op_r == OP_ADD) && !err_r, "row write outside an accepted edge insert")
  `AESF_IMPLIES(a_scan_bound, state_r == ST_SCAN, m_r <= last_r, "scan index passed the last node")
  `AESF_IMPLIES(a_err_empty, out_valid_r && out_err_r, (out_mask_r == '0) && !out_pair_r, "range error with a nonempty result")
  `AESF_IMPLIES(a_any_mask, out_valid_r, out_any_r == (out_mask_r != '0), "any flag disagrees with the mask")
  `AESF_NEXT(a_fin_load, out_load, out_valid_r && (state_r == ST_IDLE), "finished word not loaded into the output register")

endmodule

### sim/tb_addable_edge_source_finder_top.sv
// Self-checking testbench of the addable edge source finder top level.
module tb_addable_edge_source_finder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aesf_pkg::*;

  // The fourth operation code has no function and must leave every field zero.
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 80;
  localparam int IDLE_PERCENT   = 19;
  localparam int REPORT_LIMIT   = 60;

  // One result word, packed as on out_tdata from bit 66 down to bit 0.
  typedef struct packed {
    logic        range_err;
    logic        pair;
    logic        any;
    logic [63:0] mask;
  } finder_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  // Input word: [1:0] operation, [7:2] source_node, [13:8] target_node.
  logic [15:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // Result word: [63:0] addable_mask, [64] any_addable, [65] pair_addable,
  // [66] range_error.
  logic [71:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_NODE_COUNT;
  logic [6:0]  cfg_data = '0;

  // Shadow graph and registers used to predict each result.
  logic [63:0]    graph_rows [64];
  logic [6:0]     node_cnt = NODE_COUNT_RST;
  logic           two_hop = 1'b1;
  finder_result_t pending_results [$];

  int  words_sent = 0;
  int  results_seen = 0;
  int  errors = 0;
  int  masks_nonempty = 0;
  int  pairs_allowed = 0;
  int  range_errs = 0;
  int  configs_applied = 0;
  int  cycles = 0;
  int  hold_request = 0;
  int  hold_left = 0;
  bit  tx_stalls = 1'b1;
  bit  rx_stalls = 1'b1;

  addable_edge_source_finder_top #(
    .MAX_NODES(64)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side readiness: random stalls, calm stretches and one long hold-off.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!rx_stalls) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Effective node count; larger register values saturate.
  function automatic int active_nodes();
    return (node_cnt > 7'd64) ? 64 : int'(node_cnt);
  endfunction

  // Sources that may add an edge into tgt among the first n nodes.
  function automatic logic [63:0] addable_sources(int tgt, int n);
    logic [63:0] in_range, direct, cand;
    int m;
    in_range = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    direct = graph_rows[tgt] & in_range;
    if (two_hop) begin
      cand = '0;
      for (m = 0; m < n; m++) begin
        if (direct[m]) cand |= graph_rows[m];
      end
    end else begin
      cand = '1;
    end
    cand &= in_range & ~direct;
    cand[tgt] = 1'b0;
    return cand;
  endfunction

  // Works out the result of one accepted word and applies an edge insert.
  function automatic finder_result_t predict_word(logic [1:0] op, logic [5:0] src,
                                                  logic [5:0] tgt);
    finder_result_t r;
    logic [63:0] sources;
    int n;
    r = '0;
    n = active_nodes();
    case (op)
      OP_ADD: begin
        if (src >= n || tgt >= n) r.range_err = 1'b1;
        else graph_rows[tgt][src] = 1'b1;
      end
      OP_QUERY: begin
        if (tgt >= n) begin
          r.range_err = 1'b1;
        end else begin
          r.mask = addable_sources(tgt, n);
          r.any = |r.mask;
        end
      end
      OP_PAIR: begin
        if (src >= n || tgt >= n) begin
          r.range_err = 1'b1;
        end else begin
          sources = addable_sources(tgt, n);
          r.pair = sources[src];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Node index for random words: mostly in range, sometimes anywhere.
  function automatic logic [5:0] random_node(int n);
    if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, n - 1));
  endfunction

  // Offers one word, waits for it to be taken, then idles at random.
  // Valid stays high when the next word follows at once.
  task automatic send_word(logic [1:0] op, logic [5:0] src, logic [5:0] tgt);
    int gap;
    finder_result_t expected;
    in_tdata <= {2'b00, tgt, src, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected = predict_word(op, src, tgt);
    pending_results.insert(pending_results.size(), expected);
    words_sent++;
    gap = (tx_stalls && $urandom_range(0, 99) < IDLE_PERCENT) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_word(int n);
    logic [1:0] op;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_ADD;
    else if (r < 70) op = OP_QUERY;
    else if (r < 95) op = OP_PAIR;
    else op = OP_NOP;
    send_word(op, random_node(n), random_node(n));
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (results_seen < words_sent) @(posedge clk);
  endtask

  // Writes both registers back to back; only called with the block idle.
  task automatic set_config(logic [6:0] count, logic hop);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NODE_COUNT;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    node_cnt = count;
    cfg_index <= CFG_TWO_HOP;
    cfg_data <= {6'd0, hop};
    do @(posedge clk); while (!cfg_ready);
    two_hop = hop;
    cfg_valid <= 1'b0;
    configs_applied++;
  endtask

  // Compares each accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_results
    finder_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[66:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result word with nothing pending, actual %h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (want.any) masks_nonempty++;
        if (want.pair) pairs_allowed++;
        if (want.range_err) range_errs++;
        if (got.mask !== want.mask) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: addable_mask expected %h, actual %h", $time, want.mask, got.mask);
        end
        if (got.any !== want.any) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: any_addable expected %b, actual %b", $time, want.any, got.any);
        end
        if (got.pair !== want.pair) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: pair_addable expected %b, actual %b", $time, want.pair, got.pair);
        end
        if (got.range_err !== want.range_err) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: range_error expected %b, actual %b", $time, want.range_err,
                     got.range_err);
        end
      end
    end
  end

  // Queries on the empty graph right after reset, plus the unused operation.
  task automatic test_empty_graph();
    send_word(OP_QUERY, 6'd0, 6'd0);
    send_word(OP_NOP, 6'd63, 6'd63);
    wait_drained();
  endtask

  // Builds a small graph in two-hop mode, with a self loop and a repeated edge.
  task automatic test_two_hop_edges();
    send_word(OP_ADD, 6'd1, 6'd0);
    send_word(OP_ADD, 6'd2, 6'd1);
    send_word(OP_ADD, 6'd63, 6'd1);
    send_word(OP_ADD, 6'd63, 6'd63);
    send_word(OP_ADD, 6'd2, 6'd1);
    send_word(OP_QUERY, 6'd0, 6'd0);
    send_word(OP_PAIR, 6'd2, 6'd0);
    send_word(OP_PAIR, 6'd1, 6'd0);
    send_word(OP_ADD, 6'd0, 6'd63);
    send_word(OP_QUERY, 6'd0, 6'd63);
    wait_drained();
  endtask

  // Plain mode: every in-range node that is not the target or a direct in-neighbor counts.
  task automatic test_plain_mode();
    set_config(7'd64, 1'b0);
    send_word(OP_QUERY, 6'd0, 6'd0);
    send_word(OP_PAIR, 6'd40, 6'd0);
    wait_drained();
  endtask

  // Node count of zero, a saturating count, and counts that hide old edges.
  task automatic test_node_count_limits();
    set_config(7'd0, 1'b1);
    send_word(OP_ADD, 6'd0, 6'd0);
    send_word(OP_QUERY, 6'd0, 6'd0);
    send_word(OP_PAIR, 6'd0, 6'd0);
    wait_drained();
    set_config(7'd127, 1'b0);
    send_word(OP_QUERY, 6'd0, 6'd63);
    wait_drained();
    set_config(7'd2, 1'b1);
    send_word(OP_QUERY, 6'd0, 6'd0);
    send_word(OP_ADD, 6'd5, 6'd1);
    send_word(OP_ADD, 6'd1, 6'd5);
    send_word(OP_PAIR, 6'd63, 6'd0);
    send_word(OP_QUERY, 6'd0, 6'd2);
    wait_drained();
    set_config(7'd1, 1'b0);
    send_word(OP_QUERY, 6'd0, 6'd0);
    send_word(OP_PAIR, 6'd0, 6'd0);
    wait_drained();
  endtask

  // The result side holds off while words keep coming, so the input stalls.
  task automatic test_backpressure();
    int i;
    set_config(7'd64, 1'b1);
    hold_request = RX_HOLD_CYCLES;
    for (i = 0; i < 30; i++) send_random_word(active_nodes());
    wait_drained();
  endtask

  // Phases of random traffic, each under its own register setting.
  task automatic test_random_traffic();
    int phase, i, r;
    logic [6:0] count;
    for (phase = 0; phase < 12; phase++) begin
      r = $urandom_range(0, 9);
      if (phase == 0) count = 7'd64;
      else if (phase == 11) count = 7'd64;
      else if (r == 0) count = 7'($urandom_range(65, 127));
      else if (r == 1) count = 7'($urandom_range(1, 3));
      else count = 7'($urandom_range(4, 64));
      set_config(count, (phase == 11) ? 1'b0 : 1'($urandom_range(0, 1)));
      // One phase runs with no idling on either side.
      tx_stalls = (phase != 4);
      rx_stalls = (phase != 4);
      for (i = 0; i < 115; i++) send_random_word(active_nodes());
      wait_drained();
    end
    tx_stalls = 1'b1;
    rx_stalls = 1'b1;
  endtask

  initial begin
    foreach (graph_rows[i]) graph_rows[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_graph();
    test_two_hop_edges();
    test_plain_mode();
    test_node_count_limits();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d result words for %0d input words over %0d register settings.",
             results_seen, words_sent, configs_applied);
    $display("Nonempty source masks: %0d, allowed pairs: %0d, range errors: %0d.",
             masks_nonempty, pairs_allowed, range_errs);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
